// ----- rtl/seeded_permutation_shuffle_unit_defines.svh -----
// assertion macros shared by the shuffle unit
`ifndef SEEDED_PERMUTATION_SHUFFLE_UNIT_DEFINES_SVH
`define SEEDED_PERMUTATION_SHUFFLE_UNIT_DEFINES_SVH

// same-cycle implication
`define SPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shuffle unit: same-cycle check failed");

// next-cycle implication
`define SPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shuffle unit: next-cycle check failed");

`endif

// ----- rtl/sps_pkg.sv -----
// shared types and constants for the seeded permutation shuffle
package sps_pkg;

  localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;

  // remainder unit consumes this many dividend bits per cycle
  localparam int MOD_BITS_PER_STEP = 4;
  localparam int MOD_STEPS         = 32 / MOD_BITS_PER_STEP;
  localparam int MOD_CNT_W         = $clog2(MOD_STEPS);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_FILL,
    OP_ADVANCE,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_MIXB,
    OP_MODLOAD,
    OP_MODSTEP,
    OP_RDSWAP,
    OP_WR1,
    OP_WR2,
    OP_RDOUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   use_b;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic pos_last;
    logic shown_last;
  } sts_t;

endpackage

// ----- rtl/seeded_permutation_shuffle_unit.sv -----
// top level of the seeded permutation shuffle unit
//
//   channel  signals                                  dir  beats per item
//   in       in_valid in_ready seed                   in   1
//   out      out_valid out_ready entry_index          out  TABLE_SIZE
//            entry_value last_entry
//
// an item fills TABLE_SIZE table entries, runs TABLE_SIZE-1 swap rounds, then
// gives each output beat as a table read followed by the shown beat
// each round uses the shared 32x32 multiplier (two mixes of three partial
// products) and the 4-bit-per-cycle remainder unit
// reset clears the controller only; table and seed are rebuilt by every item
// in_ready is low from seed accept until the last entry beat is taken
// out_ready low holds the current beat; the next table read waits for it
`include "seeded_permutation_shuffle_unit_defines.svh"

module seeded_permutation_shuffle_unit import sps_pkg::*; #(
  parameter int TABLE_SIZE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] seed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  entry_index,
  output logic [3:0]  entry_value,
  output logic        last_entry
);

  cmd_t cmd;
  sts_t sts;

  sps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sps_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .seed        (seed),
    .sts         (sts),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .last_entry  (last_entry)
  );

  `SPS_ASSERT_IMPL(a_in_out_exclusive, clk, rst, in_ready, !out_valid)
  `SPS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `SPS_ASSERT_NEXT(a_idle_after_last, clk, rst, out_valid && out_ready && last_entry, in_ready)
  `SPS_ASSERT_NEXT(a_busy_mid_table, clk, rst, out_valid && out_ready && !last_entry, !in_ready)

endmodule

// ----- rtl/sps_ctrl.sv -----
// sequencing state machine for the shuffle unit
module sps_ctrl import sps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_ADV,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MIXB,
    S_MODLD,
    S_MOD,
    S_RDSW,
    S_WR1,
    S_WR2,
    S_RDOUT,
    S_SHOW
  } state_t;

  state_t               state;
  logic                 pass_b;
  logic [MOD_CNT_W-1:0] cnt;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_SHOW);

  always_comb begin
    cmd.use_b = pass_b;
    case (state)
      S_IDLE:  cmd.op = in_valid ? OP_START : OP_NONE;
      S_FILL:  cmd.op = OP_FILL;
      S_ADV:   cmd.op = OP_ADVANCE;
      S_MUL0:  cmd.op = OP_MUL0;
      S_MUL1:  cmd.op = OP_MUL1;
      S_MUL2:  cmd.op = OP_MUL2;
      S_MIXB:  cmd.op = OP_MIXB;
      S_MODLD: cmd.op = OP_MODLOAD;
      S_MOD:   cmd.op = OP_MODSTEP;
      S_RDSW:  cmd.op = OP_RDSWAP;
      S_WR1:   cmd.op = OP_WR1;
      S_WR2:   cmd.op = OP_WR2;
      S_RDOUT: cmd.op = OP_RDOUT;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pass_b <= 1'b0;
      cnt    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_FILL;
        end
        S_FILL: begin
          if (sts.idx_last) state <= S_ADV;
        end
        S_ADV: begin
          pass_b <= 1'b0;
          state  <= S_MUL0;
        end
        S_MUL0: state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= pass_b ? S_MODLD : S_MIXB;
        S_MIXB: begin
          pass_b <= 1'b1;
          state  <= S_MUL0;
        end
        S_MODLD: begin
          cnt   <= '0;
          state <= S_MOD;
        end
        S_MOD: begin
          cnt <= cnt + 1'b1;
          if (cnt == MOD_CNT_W'(MOD_STEPS - 1)) state <= S_RDSW;
        end
        S_RDSW: state <= S_WR1;
        S_WR1:  state <= S_WR2;
        S_WR2:  state <= sts.pos_last ? S_RDOUT : S_ADV;
        S_RDOUT: state <= S_SHOW;
        S_SHOW: begin
          if (out_ready) state <= sts.shown_last ? S_IDLE : S_RDOUT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/sps_datapath.sv -----
// seed generator, shared multiplier, remainder unit and permutation memory
module sps_datapath import sps_pkg::*; #(
  parameter int TABLE_SIZE = 16
) (
  input  logic        clk,
  input  cmd_t        cmd,
  input  logic [63:0] seed,
  output sts_t        sts,
  output logic [3:0]  entry_index,
  output logic [3:0]  entry_value,
  output logic        last_entry
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);

  logic [IW-1:0] mem [TABLE_SIZE];

  logic [63:0]   rseed;
  logic [63:0]   mop;
  logic [63:0]   acc;
  logic [31:0]   dvd;
  logic [IW-1:0] rem;
  logic [IW-1:0] pos;
  logic [IW-1:0] idx;
  logic [IW-1:0] oidx;
  logic [IW-1:0] oval;
  logic          olast;
  logic [IW-1:0] rd_pos;
  logic [IW-1:0] rd_pick;

  logic [63:0]   seed_next;
  logic [63:0]   kmul;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   prod;
  logic [63:0]   mix_out;
  logic [IW:0]   dvsr;
  logic [IW-1:0] rem_next;
  logic          idx_last;

  logic          we;
  logic [IW-1:0] waddr;
  logic [IW-1:0] wdata;

  assign seed_next = rseed + GOLDEN_INC;
  assign kmul      = cmd.use_b ? MIX_MUL_B : MIX_MUL_A;
  assign mix_out   = acc ^ (acc >> 31);
  assign idx_last  = (idx == LAST_IDX);

  // 64x64 low product as three 32x32 partial products in MUL0, MUL1 and MUL2
  always_comb begin
    mul_a = (cmd.op == OP_MUL2) ? mop[63:32] : mop[31:0];
    mul_b = (cmd.op == OP_MUL1) ? kmul[63:32] : kmul[31:0];
  end
  assign prod = 64'(mul_a) * 64'(mul_b);

  assign dvsr = {1'b0, pos} + {{IW{1'b0}}, 1'b1};

  // restoring remainder, msb first, MOD_BITS_PER_STEP dividend bits per step
  always_comb begin
    logic [IW:0]   t;
    logic [IW-1:0] r;
    r = rem;
    t = '0;
    for (int k = 0; k < MOD_BITS_PER_STEP; k++) begin
      t = {r, dvd[31-k]};
      if (t >= dvsr) t = t - dvsr;
      r = t[IW-1:0];
    end
    rem_next = r;
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = idx;
    case (cmd.op)
      OP_FILL: begin
        we = 1'b1;
      end
      OP_WR1: begin
        we    = 1'b1;
        waddr = pos;
        wdata = rd_pick;
      end
      OP_WR2: begin
        we    = 1'b1;
        waddr = rem;
        wdata = rd_pos;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RDSWAP) begin
      rd_pos  <= mem[pos];
      rd_pick <= mem[rem];
    end
    if (cmd.op == OP_RDOUT) oval <= mem[idx];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        rseed <= seed;
        idx   <= '0;
        pos   <= LAST_IDX;
      end
      OP_FILL: begin
        idx <= idx_last ? '0 : idx + 1'b1;
      end
      OP_ADVANCE: begin
        rseed <= seed_next;
        mop   <= seed_next ^ (seed_next >> 30);
      end
      OP_MUL0: acc <= prod;
      OP_MUL1, OP_MUL2: begin
        acc[63:32] <= acc[63:32] + prod[31:0];
      end
      OP_MIXB: mop <= acc ^ (acc >> 27);
      OP_MODLOAD: begin
        dvd <= mix_out[31:0];
        rem <= '0;
      end
      OP_MODSTEP: begin
        dvd <= dvd << MOD_BITS_PER_STEP;
        rem <= rem_next;
      end
      OP_WR2: pos <= pos - 1'b1;
      OP_RDOUT: begin
        oidx  <= idx;
        olast <= idx_last;
        idx   <= idx_last ? '0 : idx + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sts.idx_last   = idx_last;
  assign sts.pos_last   = (pos == IW'(1));
  assign sts.shown_last = olast;

  assign entry_index = 4'(oidx);
  assign entry_value = 4'(oval);
  assign last_entry  = olast;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the seeded permutation shuffle unit
module testbench import sps_pkg::*; ();

  localparam int TABLE_LEN        = 16;
  localparam int NUM_ITEMS        = 460;
  localparam int NUM_DIRECTED     = 13;
  localparam int QUIET_ITEMS      = 30;
  localparam int HOLD_AFTER_BEATS = 640;
  localparam int HOLD_CYCLES      = 600;
  localparam int DRAIN_CYCLES     = 400;
  localparam int STALL_LIMIT      = 5000;

  typedef struct packed {
    logic [3:0] pos;
    logic [3:0] val;
    logic       last;
  } entry_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] seed;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  entry_index;
  logic [3:0]  entry_value;
  logic        last_entry;

  entry_t pending_entries[$];
  int     errors      = 0;
  int     beats_taken = 0;
  int     idle_cycles = 0;
  bit     quiet       = 1'b0;
  bit     hold_done   = 1'b0;

  // every row goes through the shuffle predictor
  logic [63:0] directed_seeds [NUM_DIRECTED] = '{
    64'h0000_0000_0000_0000,  // first item after reset: table and seed start unwritten
    64'hFFFF_FFFF_FFFF_FFFF,
    64'h0000_0000_0000_0001,
    64'h8000_0000_0000_0000,
    64'h5555_5555_5555_5555,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h61C8_8646_80B5_83EB,  // first advance wraps the running seed to zero
    64'h9E37_79B9_7F4A_7C15,
    64'h0000_0000_FFFF_FFFF,
    64'hFFFF_FFFF_0000_0000,
    64'h0000_0000_0000_0000,  // same seed again must rebuild the same table
    64'h0123_4567_89AB_CDEF,
    64'hFEDC_BA98_7654_3210
  };

  seeded_permutation_shuffle_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .seed       (seed),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .entry_index(entry_index),
    .entry_value(entry_value),
    .last_entry (last_entry)
  );

  function automatic logic [63:0] splitmix(input logic [63:0] z);
    z = (z ^ (z >> 30)) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  // fisher-yates over the identity; entry k of the result sits in bits 4k+3:4k
  function automatic logic [63:0] shuffle_seed(input logic [63:0] start);
    logic [3:0]  perm [TABLE_LEN];
    logic [63:0] state;
    logic [63:0] mixed;
    logic [31:0] span;
    logic [31:0] pick;
    logic [3:0]  swap_val;
    logic [63:0] packed_perm;
    for (int k = 0; k < TABLE_LEN; k++) perm[k] = 4'(k);
    state = start;
    for (int p = TABLE_LEN - 1; p > 0; p--) begin
      state = state + GOLDEN_INC;
      mixed = splitmix(state);
      span = 32'(p + 1);
      pick = mixed[31:0] % span;
      swap_val = perm[p];
      perm[p] = perm[pick];
      perm[pick] = swap_val;
    end
    for (int k = 0; k < TABLE_LEN; k++) packed_perm[4*k +: 4] = perm[k];
    return packed_perm;
  endfunction

  function automatic logic [63:0] random_seed();
    case ($urandom_range(0, 7))
      0:       return 64'd1 << $urandom_range(0, 63);
      1:       return 64'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic offer_seed(input logic [63:0] value);
    in_valid <= 1'b1;
    seed     <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reset, seed beats, and the end of the run
  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    seed     <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < NUM_ITEMS; n++) begin
      if (n >= NUM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      offer_seed(n < NUM_DIRECTED ? directed_seeds[n] : random_seed());
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** seeded_permutation_shuffle_unit: PASSED **");
    end else begin
      $display("** seeded_permutation_shuffle_unit: FAILED **");
    end
    $finish;
  end

  // receiver: short random stalls plus one long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && beats_taken >= HOLD_AFTER_BEATS) begin
        // unit fills up and keeps in_ready low while seeds wait
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // prediction on seed beats, checking on entry beats, stall watchdog
  always @(posedge clk) begin
    logic [63:0] perm_vals;
    entry_t      fresh;
    entry_t      want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        perm_vals = shuffle_seed(seed);
        for (int k = 0; k < TABLE_LEN; k++) begin
          fresh.pos  = 4'(k);
          fresh.val  = perm_vals[4*k +: 4];
          fresh.last = (k == TABLE_LEN - 1);
          pending_entries.push_back(fresh);
        end
      end
      if (out_valid && out_ready) begin
        beats_taken++;
        if (pending_entries.size() == 0) begin
          $display("%0t: beat with nothing expected, index %0d value %0d last %0b",
                   $time, entry_index, entry_value, last_entry);
          errors++;
        end else begin
          want = pending_entries.pop_front();
          if (entry_index !== want.pos) begin
            $display("%0t: entry_index expected %0d actual %0d", $time, want.pos, entry_index);
            errors++;
          end
          if (entry_value !== want.val) begin
            $display("%0t: entry_value expected %0d actual %0d", $time, want.val, entry_value);
            errors++;
          end
          if (last_entry !== want.last) begin
            $display("%0t: last_entry expected %0b actual %0b", $time, want.last, last_entry);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("** seeded_permutation_shuffle_unit: FAILED **");
        $finish;
      end
    end
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sps_pkg.sv
rtl/sps_ctrl.sv
rtl/sps_datapath.sv
rtl/seeded_permutation_shuffle_unit.sv
tb/testbench.sv
